// ===== design/htb_pkg.sv =====
// Shared constants and types for the Huffman tree builder.
package htb_pkg;
    localparam int MAX_LEAVES_DEF = 32;
    localparam int IDX_W = 6;
    localparam int LW_W = 16;
    localparam int NW_W = 21;

    typedef struct packed {
        logic          valid;
        logic [IDX_W-1:0] idx;
        logic [NW_W-1:0]  weight;
    } htb_entry_t;
endpackage

// ===== design/htb_cell.sv =====
// One cell of the sorted list: holds an entry and shifts toward the head or tail.
module htb_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               clear,
    input  logic               ins_en,
    input  logic               pop_en,
    input  htb_pkg::htb_entry_t new_entry,
    input  htb_pkg::htb_entry_t prev_entry,
    input  htb_pkg::htb_entry_t next2_entry,
    input  logic               prev_before,
    output logic               stays,
    output htb_pkg::htb_entry_t entry
);
    import htb_pkg::*;

    htb_entry_t entry_reg;
    htb_entry_t entry_next;

    // Insertion puts the new entry after all entries of not greater weight
    // when loading leaves (stable), and the build node before equal weights.
    assign entry = entry_reg;
    assign stays = entry_reg.valid && !(new_entry.weight < entry_reg.weight) &&
                   !(pop_en && entry_reg.weight == new_entry.weight);

    always_comb
    begin
        entry_next = entry_reg;
        if (clear)
        begin
            entry_next.valid = 1'b0;
        end
        else if (pop_en)
        begin
            // Pop two from the head while inserting the merged node.
            if (next2_entry.valid && (next2_entry.weight < new_entry.weight))
            begin
                entry_next = next2_entry;
            end
            else if (prev_before)
            begin
                entry_next = new_entry;
            end
            else
            begin
                entry_next = prev_entry;
            end
        end
        else if (ins_en)
        begin
            if (stays)
            begin
                entry_next = entry_reg;
            end
            else if (prev_before)
            begin
                entry_next = new_entry;
            end
            else
            begin
                entry_next = prev_entry;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg.valid <= 1'b0;
            entry_reg.idx <= '0;
            entry_reg.weight <= '0;
        end
        else
        begin
            entry_reg <= entry_next;
        end
    end
endmodule

// ===== design/huffman_tree_builder_core.sv =====
// Top level of the Huffman tree builder: leaf loading, list cells and build control.
//
// Usage: drive leaf_weight and final_leaf with start; a transfer happens at a
// clock edge where start is high and busy is low. Each leaf is placed into a
// row of list cells by sorted insertion, so leaves load one per cycle while
// busy stays low. The leaf marked final_leaf starts the build: busy is high
// while the build runs, one pop-and-insert step of the cell row per tree node,
// and every step registers one result. Results are shown for one cycle each
// with done high, back to back, the first registered by the first build step;
// the root, marked by is_root, is shown in the cycle in which busy falls. A
// single leaf holds busy high in a single-leaf state and then gives one result
// for itself. No new transfer is taken until busy falls. Leaves beyond
// MAX_LEAVES are ignored. The receiver cannot stall; results must be taken
// when shown.
// Reset empties the cell row and clears the leaf count at once.
module huffman_tree_builder_core #(
    parameter int MAX_LEAVES = htb_pkg::MAX_LEAVES_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [htb_pkg::LW_W-1:0]   leaf_weight,
    input  logic                       final_leaf,
    output logic                       done,
    output logic [htb_pkg::IDX_W-1:0]  node_index,
    output logic [htb_pkg::IDX_W-1:0]  left_child,
    output logic [htb_pkg::IDX_W-1:0]  right_child,
    output logic [htb_pkg::NW_W-1:0]   node_weight_out,
    output logic                       is_root
);
    import htb_pkg::*;

    localparam int CW = $clog2(MAX_LEAVES + 1);

    typedef enum logic [1:0] {S_LOAD, S_BUILD, S_SINGLE} state_t;

    state_t           state_reg;
    logic [CW-1:0]    count_reg;
    logic [IDX_W-1:0] next_idx_reg;
    logic [IDX_W-1:0] last_idx_reg;
    logic             done_reg;
    logic [IDX_W-1:0] node_reg;
    logic [IDX_W-1:0] left_reg;
    logic [IDX_W-1:0] right_reg;
    logic [NW_W-1:0]  weight_reg;
    logic             root_reg;

    htb_entry_t cells [MAX_LEAVES];
    logic       bef [MAX_LEAVES];
    htb_entry_t new_entry;
    logic       accept;
    logic       ins_en;
    logic       pop_en;
    logic       clear;
    logic [NW_W-1:0] sum;

    assign accept = start && !busy;
    assign ins_en = accept && (count_reg < CW'(MAX_LEAVES));
    assign pop_en = (state_reg == S_BUILD);
    assign clear  = (state_reg == S_SINGLE) ||
                    (pop_en && next_idx_reg == last_idx_reg);
    assign sum    = cells[0].weight + cells[1].weight;

    always_comb
    begin
        new_entry.valid = 1'b1;
        if (pop_en)
        begin
            new_entry.idx    = next_idx_reg;
            new_entry.weight = sum;
        end
        else
        begin
            new_entry.idx    = IDX_W'(count_reg);
            new_entry.weight = NW_W'(leaf_weight);
        end
    end

    genvar g;
    generate
        for (g = 0; g < MAX_LEAVES; g++)
        begin : g_cell
            htb_entry_t prv;
            htb_entry_t nx1;
            htb_entry_t nx2;
            logic       pb;
            if (g + 1 < MAX_LEAVES)
            begin : g_n1
                assign nx1 = cells[g + 1];
            end
            else
            begin : g_n1z
                assign nx1 = '0;
            end
            if (g + 2 < MAX_LEAVES)
            begin : g_n2
                assign nx2 = cells[g + 2];
            end
            else
            begin : g_n2z
                assign nx2 = '0;
            end
            if (g == 0)
            begin : g_first
                assign prv = pop_en ? nx1 : new_entry;
                assign pb  = 1'b1;
            end
            else
            begin : g_rest
                assign prv = pop_en ? nx1 : cells[g - 1];
                assign pb  = pop_en ? (nx1.valid && (nx1.weight < new_entry.weight))
                                    : bef[g - 1];
            end
            htb_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .clear      (clear),
                .ins_en     (ins_en),
                .pop_en     (pop_en),
                .new_entry  (new_entry),
                .prev_entry (prv),
                .next2_entry(nx2),
                .prev_before(pb),
                .stays      (bef[g]),
                .entry      (cells[g])
            );
        end
    endgenerate

    assign busy            = (state_reg != S_LOAD);
    assign done            = done_reg;
    assign node_index      = node_reg;
    assign left_child      = left_reg;
    assign right_child     = right_reg;
    assign node_weight_out = weight_reg;
    assign is_root         = root_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_LOAD;
            count_reg    <= '0;
            next_idx_reg <= '0;
            last_idx_reg <= '0;
            done_reg     <= 1'b0;
            root_reg     <= 1'b0;
            node_reg     <= '0;
            left_reg     <= '0;
            right_reg    <= '0;
            weight_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_LOAD:
                begin
                    if (accept)
                    begin
                        if (final_leaf)
                        begin
                            count_reg <= '0;
                            if (count_reg == '0)
                            begin
                                state_reg <= S_SINGLE;
                            end
                            else
                            begin
                                state_reg    <= S_BUILD;
                                next_idx_reg <= IDX_W'(count_reg) +
                                                IDX_W'(ins_en);
                                last_idx_reg <= IDX_W'(count_reg) +
                                                IDX_W'(ins_en) + IDX_W'(count_reg) +
                                                IDX_W'(ins_en) - IDX_W'(2);
                            end
                        end
                        else if (ins_en)
                        begin
                            count_reg <= count_reg + CW'(1);
                        end
                    end
                end
                S_SINGLE:
                begin
                    done_reg   <= 1'b1;
                    root_reg   <= 1'b1;
                    node_reg   <= '0;
                    left_reg   <= '0;
                    right_reg  <= '0;
                    weight_reg <= cells[0].weight;
                    state_reg  <= S_LOAD;
                end
                S_BUILD:
                begin
                    done_reg     <= 1'b1;
                    node_reg     <= next_idx_reg;
                    left_reg     <= cells[0].idx;
                    right_reg    <= cells[1].idx;
                    weight_reg   <= sum;
                    root_reg     <= (next_idx_reg == last_idx_reg);
                    next_idx_reg <= next_idx_reg + IDX_W'(1);
                    if (next_idx_reg == last_idx_reg)
                    begin
                        state_reg <= S_LOAD;
                    end
                end
                default:
                begin
                    state_reg <= S_LOAD;
                end
            endcase
        end
    end
endmodule

// ===== design/huffman_tree_builder_core_checker.sv =====
// Port-level assertions for the Huffman tree builder, bound to the top level.
module huffman_tree_builder_core_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic final_leaf,
    input logic done,
    input logic is_root
);
    a_root_done: assert property (@(posedge clk) disable iff (!rst_n)
        is_root && done |-> 1'b1 ##0 done)
        else $error("root without strobe");
    a_root_ends: assert property (@(posedge clk) disable iff (!rst_n)
        done && is_root |-> !busy)
        else $error("busy after root");
    a_final_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && final_leaf |=> busy)
        else $error("build did not start");
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !busy && !$past(busy) |-> !done)
        else $error("result while idle");
endmodule

bind huffman_tree_builder_core huffman_tree_builder_core_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .final_leaf (final_leaf),
    .done       (done),
    .is_root    (is_root)
);

// ===== sim/huffman_tree_builder_core_test.sv =====
// Self-checking testbench for the Huffman tree builder core.
module huffman_tree_builder_core_test;
    timeunit 1ns;
    timeprecision 1ps;
    import htb_pkg::*;

    typedef struct {
        logic [IDX_W-1:0] node;
        logic [IDX_W-1:0] lchild;
        logic [IDX_W-1:0] rchild;
        logic [NW_W-1:0]  wsum;
        logic             root;
    } tree_node_t;

    int error_count = 0;

    task automatic report(input string what, input int got, input int want);
        $display("mismatch: %s got %0d want %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    class tree_scoreboard;
        logic [NW_W-1:0] weights[MAX_LEAVES_DEF*2-1];
        logic [IDX_W-1:0] order[$];
        int leaves = 0;
        tree_node_t pending_nodes[$];
        int nodes_checked = 0;
        int builds = 0;

        function void note_leaf(logic [LW_W-1:0] w, logic fin);
            int n;
            int pos;
            int j;
            logic [IDX_W-1:0] key;
            logic [IDX_W-1:0] l;
            logic [IDX_W-1:0] r;
            logic [NW_W-1:0] s;
            tree_node_t t;
            if (leaves < MAX_LEAVES_DEF) begin
                weights[leaves] = NW_W'(w);
                leaves++;
            end
            if (!fin) return;
            n = leaves;
            leaves = 0;
            builds++;
            if (n == 1) begin
                t = '{0, 0, 0, weights[0], 1'b1};
                pending_nodes.push_back(t);
                return;
            end
            order.delete();
            for (int i = 0; i < n; i++) begin
                key = IDX_W'(i);
                j = order.size();
                while (j > 0 && weights[order[j-1]] > weights[key]) j--;
                order.insert(j, key);
            end
            for (int i = 0; i + 1 < n; i++) begin
                l = order.pop_front();
                r = order.pop_front();
                s = weights[l] + weights[r];
                weights[n+i] = s;
                pos = 0;
                while (pos < order.size() && weights[order[pos]] < s) pos++;
                order.insert(pos, IDX_W'(n + i));
                t = '{IDX_W'(n + i), l, r, s, (i + 2 == n)};
                pending_nodes.push_back(t);
            end
        endfunction

        task check_node(tree_node_t got);
            tree_node_t want;
            if (pending_nodes.size() == 0) begin
                report("unexpected node", got.node, -1);
                return;
            end
            want = pending_nodes.pop_front();
            nodes_checked++;
            if (got.node !== want.node) report("node_index", got.node, want.node);
            if (got.lchild !== want.lchild) report("left_child", got.lchild, want.lchild);
            if (got.rchild !== want.rchild) report("right_child", got.rchild, want.rchild);
            if (got.wsum !== want.wsum) report("node_weight_out", got.wsum, want.wsum);
            if (got.root !== want.root) report("is_root", got.root, want.root);
        endtask
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic start = 0;
    logic [LW_W-1:0] leaf_weight = '0;
    logic final_leaf = 0;
    logic busy, done, is_root;
    logic [IDX_W-1:0] node_index, left_child, right_child;
    logic [NW_W-1:0] node_weight_out;

    tree_scoreboard sb = new();
    int cycle_count = 0;
    bit quiet_stretch = 0;
    int leaves_sent = 0;

    huffman_tree_builder_core u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .leaf_weight(leaf_weight), .final_leaf(final_leaf), .done(done),
        .node_index(node_index), .left_child(left_child),
        .right_child(right_child), .node_weight_out(node_weight_out),
        .is_root(is_root)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        tree_node_t got;
        cycle_count++;
        if (cycle_count > 400000) begin
            $display("[huffman_tree_builder_core] ERROR");
            $finish;
        end
        if (rst_n && done) begin
            got = '{node_index, left_child, right_child, node_weight_out, is_root};
            sb.check_node(got);
        end
    end

    task automatic send_leaf(input logic [LW_W-1:0] w, input logic fin);
        while (!quiet_stretch && $urandom_range(99) < 30) begin
            start <= 0;
            @(posedge clk);
        end
        start <= 1;
        leaf_weight <= w;
        final_leaf <= fin;
        @(posedge clk);
        while (busy) @(posedge clk);
        sb.note_leaf(w, fin);
        leaves_sent++;
    endtask

    task automatic send_set(input int n, input int mode);
        logic [LW_W-1:0] w;
        for (int i = 0; i < n; i++) begin
            case (mode)
                0: w = LW_W'($urandom);
                1: w = LW_W'($urandom_range(4));
                2: w = 16'hFFFF;
                default: w = LW_W'($urandom_range(1000));
            endcase
            send_leaf(w, i == n - 1);
        end
    endtask

    task automatic drain;
        start <= 0;
        while (sb.pending_nodes.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    initial begin
        int n;
        repeat (6) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        send_leaf(16'h0000, 1);
        send_leaf(16'hFFFF, 1);
        send_set(2, 2);
        send_set(3, 1);
        send_leaf(16'h5555, 0);
        send_leaf(16'hAAAA, 1);
        drain();
        // Too many leaves: the surplus beyond capacity is dropped.
        send_set(MAX_LEAVES_DEF + 3, 2);
        drain();
        quiet_stretch = 1;
        send_set(MAX_LEAVES_DEF, 1);
        send_set(10, 0);
        quiet_stretch = 0;
        while (leaves_sent < 425) begin
            n = ($urandom_range(9) == 0) ? $urandom_range(36, 30) : $urandom_range(1, 12);
            send_set(n, $urandom_range(3));
            if ($urandom_range(5) == 0) drain();
        end
        drain();
        $display("Sent %0d leaves in %0d builds; checked %0d tree nodes.",
                 leaves_sent, sb.builds, sb.nodes_checked);
        if (error_count == 0 && sb.pending_nodes.size() == 0)
            $display("[huffman_tree_builder_core] OK");
        else
            $display("[huffman_tree_builder_core] ERROR");
        $finish;
    end
endmodule

// ===== files.f =====
design/htb_pkg.sv
design/htb_cell.sv
design/huffman_tree_builder_core.sv
design/huffman_tree_builder_core_checker.sv
sim/huffman_tree_builder_core_test.sv
